// ----- sv/rlmm_pkg.sv -----
// ============================================================================
// rlmm_pkg
// Shared types, constants and the micro-program of the moment engine.
// ============================================================================
`default_nettype none

package rlmm_pkg;

    localparam int POS_W    = 25;
    localparam int H_W      = 13;
    localparam int MAX_DIM  = 4096;
    localparam int MOM_W    = 64;
    localparam int N_MOM    = 10;
    localparam int RF_DEPTH = 32;
    localparam int RA_W     = 5;
    localparam int PC_W     = 7;
    localparam int IDX_W    = 4;

    localparam logic [MOM_W-1:0] INV3 = 64'hAAAA_AAAA_AAAA_AAAB;

    // register file map
    localparam logic [RA_W-1:0] RA_ONE  = 5'd10;
    localparam logic [RA_W-1:0] RA_INV3 = 5'd11;
    localparam logic [RA_W-1:0] RA_S    = 5'd12;
    localparam logic [RA_W-1:0] RA_N    = 5'd13;
    localparam logic [RA_W-1:0] RA_T1   = 5'd14;
    localparam logic [RA_W-1:0] RA_T2   = 5'd15;
    localparam logic [RA_W-1:0] RA_TA   = 5'd16;
    localparam logic [RA_W-1:0] RA_TB   = 5'd17;
    localparam logic [RA_W-1:0] RA_X0   = 5'd18;
    localparam logic [RA_W-1:0] RA_Y0   = 5'd22;
    localparam logic [RA_W-1:0] RA_S2   = 5'd26;
    localparam logic [RA_W-1:0] RA_TMP  = 5'd27;

    // program entry points and offsets inside the rectangle routine
    localparam logic [PC_W-1:0] PC_OUT  = 7'd0;
    localparam logic [PC_W-1:0] PC_CLR  = 7'd10;
    localparam logic [PC_W-1:0] PC_ZERO = 7'd12;
    localparam logic [PC_W-1:0] PC_RECT = 7'd22;
    localparam logic [PC_W-1:0] RP_XPS  = 7'd2;
    localparam logic [PC_W-1:0] RP_YLD  = 7'd30;
    localparam logic [PC_W-1:0] RP_YPS  = 7'd32;
    localparam logic [PC_W-1:0] RP_ACC  = 7'd60;
    localparam logic [PC_W-1:0] RP_END  = 7'd80;

    typedef enum logic [2:0] {
        OP_ADD, OP_SUB, OP_MUL, OP_SHR1, OP_PASS, OP_LDI, OP_CAPT
    } op_t;

    typedef enum logic [2:0] {
        IMM_ZERO, IMM_ONE, IMM_INV3, IMM_XS, IMM_XN, IMM_YS, IMM_YN
    } imm_t;

    typedef struct packed {
        op_t             op;
        logic [RA_W-1:0] dst;
        logic [RA_W-1:0] sa;
        logic [RA_W-1:0] sb;
        imm_t            imm;
        logic            last;
    } instr_t;

    typedef struct packed {
        logic [POS_W:0]   xs;
        logic [POS_W-1:0] xn;
        logic [H_W-1:0]   ys;
        logic [POS_W-1:0] yn;
    } rect_t;

    typedef struct packed {
        logic            start;
        logic [PC_W-1:0] pc;
    } ex_ctl_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic             capt;
        logic [IDX_W-1:0] capt_idx;
        logic [MOM_W-1:0] capt_data;
    } ex_stat_t;

    typedef struct packed {
        logic             start;
        logic [POS_W-1:0] dividend;
        logic [H_W-1:0]   divisor;
    } div_ctl_t;

    typedef struct packed {
        logic             done;
        logic [POS_W-1:0] quot;
        logic [H_W-1:0]   rem;
    } div_stat_t;

    typedef enum logic [2:0] {
        EX_IDLE, EX_ISSUE, EX_EXEC, EX_MUL1, EX_MUL2, EX_MUL3
    } ex_state_t;

    typedef enum logic [3:0] {
        ST_RST_GO, ST_RST_WAIT, ST_IDLE, ST_DIV1_GO, ST_DIV1_WAIT,
        ST_DIV2_GO, ST_DIV2_WAIT, ST_RECT_GO, ST_RECT_WAIT, ST_FINISH,
        ST_OUT_GO, ST_OUT_WAIT
    } state_t;

    function automatic instr_t mk_ins(input op_t op, input logic [RA_W-1:0] dst,
                                      input logic [RA_W-1:0] sa,
                                      input logic [RA_W-1:0] sb,
                                      input imm_t imm, input logic last);
        instr_t i;
        i.op   = op;
        i.dst  = dst;
        i.sa   = sa;
        i.sb   = sb;
        i.imm  = imm;
        i.last = last;
        return i;
    endfunction

    // power sums over k = S .. S+N-1 into bank pb (count, sum k, k^2, k^3)
    function automatic instr_t ps_step(input logic [RA_W-1:0] k,
                                       input logic [RA_W-1:0] pb);
        instr_t i;
        i = mk_ins(OP_PASS, RA_TMP, RA_TMP, RA_TMP, IMM_ZERO, 1'b0);
        case (k)
            5'd0:  i = mk_ins(OP_SUB,  RA_TA, RA_N,  RA_ONE,  IMM_ZERO, 1'b0);
            5'd1:  i = mk_ins(OP_MUL,  RA_TB, RA_N,  RA_TA,   IMM_ZERO, 1'b0);
            5'd2:  i = mk_ins(OP_SHR1, RA_T1, RA_TB, RA_TB,   IMM_ZERO, 1'b0);
            5'd3:  i = mk_ins(OP_ADD,  RA_TA, RA_N,  RA_N,    IMM_ZERO, 1'b0);
            5'd4:  i = mk_ins(OP_SUB,  RA_TA, RA_TA, RA_ONE,  IMM_ZERO, 1'b0);
            5'd5:  i = mk_ins(OP_MUL,  RA_TB, RA_T1, RA_TA,   IMM_ZERO, 1'b0);
            5'd6:  i = mk_ins(OP_MUL,  RA_T2, RA_TB, RA_INV3, IMM_ZERO, 1'b0);
            5'd7:  i = mk_ins(OP_MUL,  RA_S2, RA_S,  RA_S,    IMM_ZERO, 1'b0);
            5'd8:  i = mk_ins(OP_PASS, pb,    RA_N,  RA_N,    IMM_ZERO, 1'b0);
            5'd9:  i = mk_ins(OP_MUL,  RA_TA, RA_N,  RA_S,    IMM_ZERO, 1'b0);
            5'd10: i = mk_ins(OP_ADD,  pb + 5'd1, RA_TA, RA_T1, IMM_ZERO, 1'b0);
            5'd11: i = mk_ins(OP_MUL,  RA_TA, RA_N,  RA_S2,   IMM_ZERO, 1'b0);
            5'd12: i = mk_ins(OP_MUL,  RA_TB, RA_S,  RA_T1,   IMM_ZERO, 1'b0);
            5'd13: i = mk_ins(OP_ADD,  RA_TB, RA_TB, RA_TB,   IMM_ZERO, 1'b0);
            5'd14: i = mk_ins(OP_ADD,  RA_TA, RA_TA, RA_TB,   IMM_ZERO, 1'b0);
            5'd15: i = mk_ins(OP_ADD,  pb + 5'd2, RA_TA, RA_T2, IMM_ZERO, 1'b0);
            5'd16: i = mk_ins(OP_MUL,  RA_TA, RA_S2, RA_S,    IMM_ZERO, 1'b0);
            5'd17: i = mk_ins(OP_MUL,  RA_TA, RA_N,  RA_TA,   IMM_ZERO, 1'b0);
            5'd18: i = mk_ins(OP_MUL,  RA_TB, RA_S2, RA_T1,   IMM_ZERO, 1'b0);
            5'd19: i = mk_ins(OP_ADD,  RA_TMP, RA_TB, RA_TB,  IMM_ZERO, 1'b0);
            5'd20: i = mk_ins(OP_ADD,  RA_TB, RA_TB, RA_TMP,  IMM_ZERO, 1'b0);
            5'd21: i = mk_ins(OP_ADD,  RA_TA, RA_TA, RA_TB,   IMM_ZERO, 1'b0);
            5'd22: i = mk_ins(OP_MUL,  RA_TB, RA_S,  RA_T2,   IMM_ZERO, 1'b0);
            5'd23: i = mk_ins(OP_ADD,  RA_TMP, RA_TB, RA_TB,  IMM_ZERO, 1'b0);
            5'd24: i = mk_ins(OP_ADD,  RA_TB, RA_TB, RA_TMP,  IMM_ZERO, 1'b0);
            5'd25: i = mk_ins(OP_ADD,  RA_TA, RA_TA, RA_TB,   IMM_ZERO, 1'b0);
            5'd26: i = mk_ins(OP_MUL,  RA_TB, RA_T1, RA_T1,   IMM_ZERO, 1'b0);
            5'd27: i = mk_ins(OP_ADD,  pb + 5'd3, RA_TA, RA_TB, IMM_ZERO, 1'b0);
            default: i = mk_ins(OP_PASS, RA_TMP, RA_TMP, RA_TMP, IMM_ZERO, 1'b0);
        endcase
        return i;
    endfunction

    // x and y power of moment k in output order
    function automatic logic [1:0] p_of(input logic [IDX_W-1:0] k);
        logic [1:0] p;
        case (k)
            4'd1, 4'd4, 4'd8: p = 2'd1;
            4'd3, 4'd7:       p = 2'd2;
            4'd6:             p = 2'd3;
            default:          p = 2'd0;
        endcase
        return p;
    endfunction

    function automatic logic [1:0] q_of(input logic [IDX_W-1:0] k);
        logic [1:0] q;
        case (k)
            4'd2, 4'd4, 4'd7: q = 2'd1;
            4'd5, 4'd8:       q = 2'd2;
            4'd9:             q = 2'd3;
            default:          q = 2'd0;
        endcase
        return q;
    endfunction

    function automatic instr_t rom_fetch(input logic [PC_W-1:0] pc);
        logic [PC_W-1:0] r;
        logic [PC_W-1:0] ra;
        logic [PC_W-1:0] rx;
        logic [PC_W-1:0] ry;
        logic [PC_W-1:0] rz;
        logic [IDX_W-1:0] k;
        instr_t i;
        r  = pc - PC_RECT;
        ra = r - RP_ACC;
        rx = r - RP_XPS;
        ry = r - RP_YPS;
        rz = pc - PC_ZERO;
        k  = ra[IDX_W:1];
        i  = mk_ins(OP_PASS, RA_TMP, RA_TMP, RA_TMP, IMM_ZERO, 1'b1);
        if (pc < PC_CLR) begin
            i = mk_ins(OP_CAPT, RA_TMP, pc[RA_W-1:0], RA_TMP, IMM_ZERO, 1'b0);
        end else if (pc == PC_CLR) begin
            i = mk_ins(OP_LDI, RA_ONE, RA_TMP, RA_TMP, IMM_ONE, 1'b0);
        end else if (pc < PC_ZERO) begin
            i = mk_ins(OP_LDI, RA_INV3, RA_TMP, RA_TMP, IMM_INV3, 1'b0);
        end else if (pc < PC_RECT) begin
            i = mk_ins(OP_LDI, rz[RA_W-1:0], RA_TMP, RA_TMP, IMM_ZERO,
                       pc == PC_RECT - 7'd1);
        end else if (r == 7'd0) begin
            i = mk_ins(OP_LDI, RA_S, RA_TMP, RA_TMP, IMM_XS, 1'b0);
        end else if (r < RP_XPS) begin
            i = mk_ins(OP_LDI, RA_N, RA_TMP, RA_TMP, IMM_XN, 1'b0);
        end else if (r < RP_YLD) begin
            i = ps_step(rx[RA_W-1:0], RA_X0);
        end else if (r == RP_YLD) begin
            i = mk_ins(OP_LDI, RA_S, RA_TMP, RA_TMP, IMM_YS, 1'b0);
        end else if (r < RP_YPS) begin
            i = mk_ins(OP_LDI, RA_N, RA_TMP, RA_TMP, IMM_YN, 1'b0);
        end else if (r < RP_ACC) begin
            i = ps_step(ry[RA_W-1:0], RA_Y0);
        end else if (r < RP_END) begin
            if (ra[0] == 1'b0) begin
                i = mk_ins(OP_MUL, RA_TA, RA_X0 + {3'd0, p_of(k)},
                           RA_Y0 + {3'd0, q_of(k)}, IMM_ZERO, 1'b0);
            end else begin
                i = mk_ins(OP_ADD, {1'b0, k}, {1'b0, k}, RA_TA, IMM_ZERO,
                           r == RP_END - 7'd1);
            end
        end
        return i;
    endfunction

endpackage

`default_nettype wire

// ----- sv/rlmm_ram.sv -----
// ============================================================================
// rlmm_ram
// Generic RAM, one write port and two registered read ports.
// ============================================================================
`default_nettype none

module rlmm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_a,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

`default_nettype wire

// ----- sv/rlmm_div.sv -----
// ============================================================================
// rlmm_div
// Restoring divider, one quotient bit per cycle, position by height.
// ============================================================================
`default_nettype none

module rlmm_div (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire rlmm_pkg::div_ctl_t   ctl,
    output rlmm_pkg::div_stat_t       stat
);
    import rlmm_pkg::*;

    localparam int CNT_W = $clog2(POS_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [H_W-1:0]   rem_reg;
    logic [POS_W-1:0] quo_reg;
    logic [H_W-1:0]   dvs_reg;

    logic [H_W:0] sh;
    logic [H_W:0] diff;
    logic         ge;

    assign sh   = {rem_reg, quo_reg[POS_W-1]};
    assign ge   = sh >= {1'b0, dvs_reg};
    assign diff = sh - {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == '0);
            if (ctl.start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && (cnt_reg == '0)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            quo_reg <= ctl.dividend;
            rem_reg <= '0;
            dvs_reg <= ctl.divisor;
            cnt_reg <= CNT_W'(POS_W - 1);
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[H_W-1:0] : sh[H_W-1:0];
            quo_reg <= {quo_reg[POS_W-2:0], ge};
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    assign stat.done = done_reg;
    assign stat.quot = quo_reg;
    assign stat.rem  = rem_reg;

endmodule

`default_nettype wire

// ----- sv/rlmm_exec.sv -----
// ============================================================================
// rlmm_exec
// Micro-sequenced 64-bit engine: register file, one 32x32 multiplier, adder.
// ============================================================================
`default_nettype none

module rlmm_exec (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire rlmm_pkg::ex_ctl_t  ctl,
    input  wire rlmm_pkg::rect_t    rect,
    output rlmm_pkg::ex_stat_t      stat
);
    import rlmm_pkg::*;

    ex_state_t        state_reg, state_next;
    logic [PC_W-1:0]  pc_reg, pc_next;
    logic [MOM_W-1:0] prod_reg;
    logic [MOM_W-1:0] acc_reg, acc_next;

    instr_t           ins;
    logic [MOM_W-1:0] rd_a, rd_b;
    logic [MOM_W-1:0] alu_res;
    logic [MOM_W-1:0] imm_val;
    logic [31:0]      mul_a, mul_b;
    logic             finish;
    logic             we;

    assign ins = rom_fetch(pc_reg);

    rlmm_ram #(.WIDTH(MOM_W), .DEPTH(RF_DEPTH)) u_rf (
        .aclk    (aclk),
        .we      (we),
        .waddr   (ins.dst),
        .wdata   (alu_res),
        .raddr_a (ins.sa),
        .raddr_b (ins.sb),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    always_comb begin
        case (ins.imm)
            IMM_ONE:  imm_val = 64'd1;
            IMM_INV3: imm_val = INV3;
            IMM_XS:   imm_val = {{(MOM_W-POS_W-1){1'b0}}, rect.xs};
            IMM_XN:   imm_val = {{(MOM_W-POS_W){1'b0}}, rect.xn};
            IMM_YS:   imm_val = {{(MOM_W-H_W){1'b0}}, rect.ys};
            IMM_YN:   imm_val = {{(MOM_W-POS_W){1'b0}}, rect.yn};
            default:  imm_val = '0;
        endcase
    end

    always_comb begin
        case (ins.op)
            OP_ADD:  alu_res = rd_a + rd_b;
            OP_SUB:  alu_res = rd_a - rd_b;
            OP_MUL:  alu_res = acc_reg + {prod_reg[31:0], 32'd0};
            OP_SHR1: alu_res = {1'b0, rd_a[MOM_W-1:1]};
            OP_LDI:  alu_res = imm_val;
            default: alu_res = rd_a;
        endcase
    end

    // low 64 bits of a*b from three 32x32 partial products
    always_comb begin
        case (state_reg)
            EX_MUL1: begin
                mul_a = rd_a[31:0];
                mul_b = rd_b[63:32];
            end
            EX_MUL2: begin
                mul_a = rd_a[63:32];
                mul_b = rd_b[31:0];
            end
            default: begin
                mul_a = rd_a[31:0];
                mul_b = rd_b[31:0];
            end
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            EX_IDLE:  if (ctl.start) state_next = EX_ISSUE;
            EX_ISSUE: state_next = EX_EXEC;
            EX_EXEC: begin
                if (ins.op == OP_MUL) begin
                    state_next = EX_MUL1;
                end else begin
                    state_next = ins.last ? EX_IDLE : EX_ISSUE;
                end
            end
            EX_MUL1:  state_next = EX_MUL2;
            EX_MUL2:  state_next = EX_MUL3;
            EX_MUL3:  state_next = ins.last ? EX_IDLE : EX_ISSUE;
            default:  state_next = EX_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        finish   = ((state_reg == EX_EXEC) && (ins.op != OP_MUL))
                   || (state_reg == EX_MUL3);
        we       = finish && (ins.op != OP_CAPT);
        pc_next  = pc_reg;
        acc_next = acc_reg;
        if ((state_reg == EX_IDLE) && ctl.start) begin
            pc_next = ctl.pc;
        end else if (finish && !ins.last) begin
            pc_next = pc_reg + 1'b1;
        end
        if (state_reg == EX_MUL1) begin
            acc_next = prod_reg;
        end else if (state_reg == EX_MUL2) begin
            acc_next = acc_reg + {prod_reg[31:0], 32'd0};
        end
        stat.busy      = state_reg != EX_IDLE;
        stat.done      = finish && ins.last;
        stat.capt      = (state_reg == EX_EXEC) && (ins.op == OP_CAPT);
        stat.capt_idx  = ins.sa[IDX_W-1:0];
        stat.capt_data = rd_a;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= EX_IDLE;
            pc_reg    <= '0;
        end else begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        acc_reg  <= acc_next;
    end

endmodule

`default_nettype wire

// ----- sv/run_length_mask_moments_top.sv -----
// ============================================================================
// run_length_mask_moments_top
// Raw moments up to third order of a run-length coded binary mask.
// ============================================================================
// Runs arrive column-major, one length per s_ transfer, alternating background
// and foreground, starting with background; s_tlast marks the final run of a
// mask. The ten moment sums are kept exactly modulo 2^64 and one result goes
// out on m_ after the last run, then all state clears. A background run or an
// empty run needs no division. A foreground run takes two divisions by the
// height, then up to three rectangles (partial first column, whole middle
// columns, partial last column), each on the shared 32x32 multiplier; a
// rectangle that is empty is skipped. The last run adds a pass to read out and
// clear the sums, plus any time the previous result still waits on m_. After
// reset a clearing pass runs before the first input is taken; cfg writes are
// taken only while the block is idle, never during a run.
// ============================================================================
`default_nettype none

module run_length_mask_moments_top (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // configuration: mask_height
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [12:0]  cfg_data,
    // input runs
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [31:0]  s_tdata,   // [24:0] run_length
    input  wire logic         s_tlast,   // last_run
    // results
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [471:0]      m_tdata,   // mom_00 [24:0], mom_10 [59:25],
                                         // mom_01 [94:60], mom_20 [141:95],
                                         // mom_11 [187:142], mom_02 [234:188],
                                         // mom_30 [292:235], mom_21 [350:293],
                                         // mom_12 [408:351], mom_03 [466:409]
    output logic              m_tuser    // out_of_range
);
    import rlmm_pkg::*;

    localparam logic [POS_W:0] COL_LIMIT = (POS_W+1)'(MAX_DIM - 1);

    state_t           state_reg, state_next;

    logic [H_W-1:0]   h_reg;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             phase_reg, phase_next;
    logic             err_reg, err_next;
    logic [POS_W-1:0] len_reg;
    logic             last_reg;
    logic [POS_W-1:0] col_reg;
    logic [H_W-1:0]   row_reg;
    logic [H_W-1:0]   c1_reg;
    logic [POS_W-1:0] nfull_reg;
    logic [H_W-1:0]   c3_reg;
    logic [1:0]       rect_reg, rect_next;

    logic             m_tvalid_reg;
    logic             flag_reg;
    logic [MOM_W-1:0] out_mom_reg [N_MOM];

    logic [H_W-1:0]   heff;
    logic [H_W-1:0]   room;
    logic [POS_W:0]   end_pos;
    logic [POS_W:0]   end_col;
    logic             fg;
    logic             rect_empty;
    logic             in_xfer;

    div_ctl_t  div_ctl;
    div_stat_t div_stat;
    ex_ctl_t   ex_ctl;
    ex_stat_t  ex_stat;
    rect_t     rect;

    rlmm_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (div_ctl),
        .stat    (div_stat)
    );

    rlmm_exec u_exec (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ex_ctl),
        .rect    (rect),
        .stat    (ex_stat)
    );

    // height 0 behaves as 1
    assign heff    = (h_reg == '0) ? H_W'(1) : h_reg;
    assign in_xfer = s_tvalid && s_tready;
    assign fg      = phase_reg && (len_reg != '0);

    // rows left in the first column, from the fresh division remainder
    assign room = heff - div_stat.rem;

    assign end_pos = {1'b0, pos_reg} + {1'b0, len_reg};
    assign end_col = {1'b0, col_reg} + {1'b0, nfull_reg}
                     + {{POS_W{1'b0}}, (c3_reg != '0)};

    // rectangle handed to the engine: x range times y range
    always_comb begin
        case (rect_reg)
            2'd0: begin
                rect.xs    = {1'b0, col_reg};
                rect.xn    = POS_W'(1);
                rect.ys    = row_reg;
                rect.yn    = {{(POS_W-H_W){1'b0}}, c1_reg};
                rect_empty = c1_reg == '0;
            end
            2'd1: begin
                rect.xs    = {1'b0, col_reg} + (POS_W+1)'(1);
                rect.xn    = nfull_reg;
                rect.ys    = '0;
                rect.yn    = {{(POS_W-H_W){1'b0}}, heff};
                rect_empty = nfull_reg == '0;
            end
            default: begin
                rect.xs    = {1'b0, col_reg} + {1'b0, nfull_reg} + (POS_W+1)'(1);
                rect.xn    = POS_W'(1);
                rect.ys    = '0;
                rect.yn    = {{(POS_W-H_W){1'b0}}, c3_reg};
                rect_empty = c3_reg == '0;
            end
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_RST_GO:    state_next = ST_RST_WAIT;
            ST_RST_WAIT:  if (ex_stat.done) state_next = ST_IDLE;
            ST_IDLE: begin
                if (in_xfer) begin
                    state_next = (phase_reg && (s_tdata[POS_W-1:0] != '0))
                                 ? ST_DIV1_GO : ST_FINISH;
                end
            end
            ST_DIV1_GO:   state_next = ST_DIV1_WAIT;
            ST_DIV1_WAIT: if (div_stat.done) state_next = ST_DIV2_GO;
            ST_DIV2_GO:   state_next = ST_DIV2_WAIT;
            ST_DIV2_WAIT: if (div_stat.done) state_next = ST_RECT_GO;
            ST_RECT_GO: begin
                if (!rect_empty) begin
                    state_next = ST_RECT_WAIT;
                end else if (rect_reg == 2'd2) begin
                    state_next = ST_FINISH;
                end
            end
            ST_RECT_WAIT: begin
                if (ex_stat.done) begin
                    state_next = (rect_reg == 2'd2) ? ST_FINISH : ST_RECT_GO;
                end
            end
            ST_FINISH:    state_next = last_reg ? ST_OUT_GO : ST_IDLE;
            ST_OUT_GO:    if (!m_tvalid_reg) state_next = ST_OUT_WAIT;
            ST_OUT_WAIT:  if (ex_stat.done) state_next = ST_IDLE;
            default:      state_next = ST_RST_GO;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_tready         = state_reg == ST_IDLE;
        div_ctl.start    = (state_reg == ST_DIV1_GO) || (state_reg == ST_DIV2_GO);
        div_ctl.divisor  = heff;
        div_ctl.dividend = (state_reg == ST_DIV2_GO)
                           ? len_reg - {{(POS_W-H_W){1'b0}}, c1_reg} : pos_reg;
        ex_ctl.start = 1'b0;
        ex_ctl.pc    = PC_RECT;
        case (state_reg)
            ST_RST_GO: begin
                ex_ctl.start = 1'b1;
                ex_ctl.pc    = PC_CLR;
            end
            ST_RECT_GO: begin
                ex_ctl.start = !rect_empty;
            end
            ST_OUT_GO: begin
                ex_ctl.start = !m_tvalid_reg;
                ex_ctl.pc    = PC_OUT;
            end
            default: begin
                ex_ctl.start = 1'b0;
            end
        endcase
    end

    // run bookkeeping
    always_comb begin
        pos_next   = pos_reg;
        phase_next = phase_reg;
        err_next   = err_reg;
        rect_next  = rect_reg;
        case (state_reg)
            ST_DIV2_WAIT: rect_next = 2'd0;
            ST_RECT_GO: begin
                if (rect_empty && (rect_reg != 2'd2)) rect_next = rect_reg + 1'b1;
            end
            ST_RECT_WAIT: begin
                if (ex_stat.done && (rect_reg != 2'd2)) rect_next = rect_reg + 1'b1;
            end
            ST_FINISH: begin
                pos_next   = end_pos[POS_W-1:0];
                phase_next = !phase_reg;
                err_next   = err_reg || end_pos[POS_W]
                             || (fg && (end_col > COL_LIMIT));
            end
            ST_OUT_GO: begin
                if (!m_tvalid_reg) begin
                    pos_next   = '0;
                    phase_next = 1'b0;
                    err_next   = 1'b0;
                end
            end
            default: begin
                rect_next = rect_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_RST_GO;
            h_reg        <= H_W'(1);
            pos_reg      <= '0;
            phase_reg    <= 1'b0;
            err_reg      <= 1'b0;
            rect_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            phase_reg <= phase_next;
            err_reg   <= err_next;
            rect_reg  <= rect_next;
            if (cfg_valid && cfg_ready) h_reg <= cfg_data;
            if ((state_reg == ST_OUT_WAIT) && ex_stat.done) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            len_reg  <= s_tdata[POS_W-1:0];
            last_reg <= s_tlast;
        end
        if ((state_reg == ST_DIV1_WAIT) && div_stat.done) begin
            col_reg <= div_stat.quot;
            row_reg <= div_stat.rem;
            c1_reg  <= (len_reg < {{(POS_W-H_W){1'b0}}, room})
                       ? len_reg[H_W-1:0] : room;
        end
        if ((state_reg == ST_DIV2_WAIT) && div_stat.done) begin
            nfull_reg <= div_stat.quot;
            c3_reg    <= div_stat.rem;
        end
        if ((state_reg == ST_OUT_GO) && !m_tvalid_reg) begin
            flag_reg <= err_reg;
        end
        if (ex_stat.capt) begin
            out_mom_reg[ex_stat.capt_idx] <= ex_stat.capt_data;
        end
    end

    // height only changes between runs, while nothing is being computed
    assign cfg_ready = state_reg == ST_IDLE;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tuser   = flag_reg;
    assign m_tdata   = {5'd0,
                        out_mom_reg[9][57:0], out_mom_reg[8][57:0],
                        out_mom_reg[7][57:0], out_mom_reg[6][57:0],
                        out_mom_reg[5][46:0], out_mom_reg[4][45:0],
                        out_mom_reg[3][46:0], out_mom_reg[2][34:0],
                        out_mom_reg[1][34:0], out_mom_reg[0][24:0]};

`ifndef NO_ASSERTIONS
    // input only taken while the shared engine is quiet
    a_ready_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !ex_stat.busy)
        else $error("input taken while engine busy");

    // a result appears only at the end of the readout program
    a_valid_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(ex_stat.done) && $past(state_reg == ST_OUT_WAIT))
        else $error("result valid without readout");

    // moment captures only during readout, never over a waiting result
    a_capt_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        ex_stat.capt |-> (state_reg == ST_OUT_WAIT) && !m_tvalid)
        else $error("moment capture outside readout");

    // divider finishes only while the sequencer waits for it
    a_div_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> (state_reg == ST_DIV1_WAIT) || (state_reg == ST_DIV2_WAIT))
        else $error("stray divider completion");
`endif

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// ============================================================================
// testbench
// Self-checking bench for the run-length mask moment engine.
// ============================================================================
// Masks go in as run lengths on the input stream, and the mask height is set
// on the configuration channel. A predictor in this file mirrors the exact
// 64-bit moment arithmetic and queues one expected result per mask. The
// result stream is checked field by field against that queue. Directed masks
// come first, then random masks under several idle patterns, then a long
// receiver hold-off.
// ============================================================================
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rlmm_pkg::*;

    localparam logic [63:0] POS_LIMIT = (64'd1 << POS_W) - 64'd1;
    localparam int          CFG_MASK_HEIGHT = 0;   // the only register
    localparam int          HOLD_CYCLES = 3000;

    // moment fields in output order, lowest bits of m_tdata first
    localparam int FIELD_W [10] = '{25, 35, 35, 47, 46, 47, 58, 58, 58, 58};

    typedef struct packed {
        logic [9:0][63:0] mom;
        logic             oor;
    } moments_t;

    logic         aclk = 1'b0;
    logic         aresetn;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [12:0]  cfg_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [31:0]  s_tdata;    // [24:0] run_length
    logic         s_tlast;    // last_run
    logic         m_tvalid;
    logic         m_tready;
    logic [471:0] m_tdata;    // ten moments, mom_00 at the bottom
    logic         m_tuser;    // out_of_range

    // sender / receiver idle rates, in percent
    int unsigned  send_idle;
    int unsigned  recv_idle;
    int unsigned  error_count;
    int unsigned  runs_sent;
    int unsigned  masks_checked;

    // long receiver hold-off
    event         hold_go;
    logic         hold_active = 1'b0;

    // predicted mask state
    logic [12:0]  mask_height_q;
    logic [63:0]  pix_pos;
    logic         in_foreground;
    logic [9:0][63:0] mom_acc;
    logic         range_flag;
    moments_t     pending_moments[$];

    run_length_mask_moments_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // ---------------------------------------------------------------- model
    // sum of k for k = 0..n-1, even factor halved first
    function automatic logic [63:0] sum_k(input logic [63:0] n);
        logic [63:0] a;
        logic [63:0] b;
        if (n == 0) return 64'd0;
        a = n;
        b = n - 64'd1;
        if (!a[0]) a = a >> 1;
        else b = b >> 1;
        return a * b;
    endfunction

    // sum of k^2 for k = 0..n-1; n(n-1)(2n-1)/6 with exact divisions first
    function automatic logic [63:0] sum_k2(input logic [63:0] n);
        logic [63:0] f [3];
        bit halved;
        bit thirded;
        if (n == 0) return 64'd0;
        f[0] = n - 64'd1;
        f[1] = n;
        f[2] = 64'd2 * n - 64'd1;
        halved = 1'b0;
        thirded = 1'b0;
        for (int i = 0; i < 3; i++) begin
            if (!halved && !f[i][0]) begin
                f[i] = f[i] >> 1;
                halved = 1'b1;
            end
        end
        for (int i = 0; i < 3; i++) begin
            if (!thirded && f[i] % 64'd3 == 64'd0) begin
                f[i] = f[i] / 64'd3;
                thirded = 1'b1;
            end
        end
        return f[0] * f[1] * f[2];
    endfunction

    // power sums of k over k = s..s+n-1
    task automatic range_powers(input logic [63:0] s, input logic [63:0] n,
                                output logic [63:0] p1, output logic [63:0] p2,
                                output logic [63:0] p3);
        logic [63:0] t1;
        logic [63:0] t2;
        logic [63:0] s2;
        t1 = sum_k(n);
        t2 = sum_k2(n);
        s2 = s * s;
        p1 = n * s + t1;
        p2 = n * s2 + 64'd2 * s * t1 + t2;
        p3 = n * s2 * s + 64'd3 * s2 * t1 + 64'd3 * s * t2 + t1 * t1;
    endtask

    // c pixels of column x starting at row y0
    task automatic add_column_piece(input logic [63:0] x, input logic [63:0] y0,
                                    input logic [63:0] c);
        logic [63:0] y1;
        logic [63:0] y2;
        logic [63:0] y3;
        logic [63:0] x2;
        if (c == 0) return;
        x2 = x * x;
        range_powers(y0, c, y1, y2, y3);
        mom_acc[0] += c;
        mom_acc[1] += x * c;
        mom_acc[2] += y1;
        mom_acc[3] += x2 * c;
        mom_acc[4] += x * y1;
        mom_acc[5] += y2;
        mom_acc[6] += x2 * x * c;
        mom_acc[7] += x2 * y1;
        mom_acc[8] += x * y2;
        mom_acc[9] += y3;
    endtask

    // n whole columns from column x0, h rows each
    task automatic add_whole_columns(input logic [63:0] x0, input logic [63:0] n,
                                     input logic [63:0] h);
        logic [63:0] x1;
        logic [63:0] x2;
        logic [63:0] x3;
        logic [63:0] c1;
        logic [63:0] c2;
        logic [63:0] c3;
        if (n == 0) return;
        range_powers(x0, n, x1, x2, x3);
        range_powers(64'd0, h, c1, c2, c3);
        mom_acc[0] += n * h;
        mom_acc[1] += x1 * h;
        mom_acc[2] += n * c1;
        mom_acc[3] += x2 * h;
        mom_acc[4] += x1 * c1;
        mom_acc[5] += n * c2;
        mom_acc[6] += x3 * h;
        mom_acc[7] += x2 * c1;
        mom_acc[8] += x1 * c2;
        mom_acc[9] += n * c3;
    endtask

    task automatic clear_mask_state();
        pix_pos = '0;
        in_foreground = 1'b0;
        mom_acc = '0;
        range_flag = 1'b0;
    endtask

    // advance the predictor by one accepted run
    task automatic predict_run(input logic [24:0] run_len, input logic is_last);
        logic [63:0] len;
        logic [63:0] h;
        logic [63:0] stop;
        logic [63:0] row;
        logic [63:0] col;
        logic [63:0] c1;
        logic [63:0] nfull;
        logic [63:0] c3;
        moments_t    res;
        len  = 64'(run_len);
        h    = (mask_height_q == 0) ? 64'd1 : 64'(mask_height_q);
        stop = pix_pos + len;
        if (in_foreground && len > 0) begin
            row = pix_pos % h;
            col = pix_pos / h;
            c1  = (len < h - row) ? len : h - row;
            add_column_piece(col, row, c1);
            if (c1 < len) begin
                nfull = (len - c1) / h;
                c3    = len - c1 - nfull * h;
                add_whole_columns(col + 64'd1, nfull, h);
                add_column_piece(col + nfull + 64'd1, 64'd0, c3);
            end
            if ((stop - 64'd1) / h > 64'(MAX_DIM - 1)) range_flag = 1'b1;
        end
        if (stop > POS_LIMIT) range_flag = 1'b1;
        pix_pos = stop & POS_LIMIT;
        in_foreground = !in_foreground;
        if (is_last) begin
            for (int j = 0; j < 10; j++)
                res.mom[j] = mom_acc[j] & ((64'd1 << FIELD_W[j]) - 64'd1);
            res.oor = range_flag;
            pending_moments.push_back(res);
            clear_mask_state();
        end
    endtask

    // ---------------------------------------------------------------- checks
    task automatic report_mismatch(input string what);
        error_count++;
        $display("[%0t] MISMATCH: %s", $realtime, what);
    endtask

    // hold-off stretch, counted here in cycles
    initial begin
        forever begin
            @(hold_go);
            hold_active <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge aclk);
            hold_active <= 1'b0;
        end
    end

    // result side: random ready, held off on request, compare per transfer
    always @(posedge aclk) begin
        moments_t    want;
        logic [63:0] got;
        int          off;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (hold_active) begin
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle);
            end
            if (m_tvalid && m_tready) begin
                if (pending_moments.size() == 0) begin
                    report_mismatch("result with nothing expected");
                end else begin
                    want = pending_moments.pop_front();
                    masks_checked++;
                    off = 0;
                    for (int j = 0; j < 10; j++) begin
                        got = 64'(m_tdata >> off) & ((64'd1 << FIELD_W[j]) - 64'd1);
                        if (got !== want.mom[j])
                            report_mismatch($sformatf("moment %0d got %0h want %0h",
                                                      j, got, want.mom[j]));
                        off += FIELD_W[j];
                    end
                    if (m_tuser !== want.oor)
                        report_mismatch($sformatf("out_of_range got %b want %b",
                                                  m_tuser, want.oor));
                end
            end
        end
    end

    // ---------------------------------------------------------------- drivers
    // all tasks start and end right after a rising edge

    // one run transfer; after it the sender idles cycle by cycle at send_idle
    task automatic send_run(input logic [24:0] run_len, input logic is_last);
        s_tdata  <= {7'd0, run_len};
        s_tlast  <= is_last;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        predict_run(run_len, is_last);
        runs_sent++;
        if ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle);
        end
    endtask

    // sender stops until every queued result has been seen
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_moments.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    task automatic write_height(input logic [12:0] value);
        drain_results();
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        // index is always the height register
        if (CFG_MASK_HEIGHT == 0) mask_height_q = value;
    endtask

    // run length scaled to the height, with empties and huge runs mixed in
    function automatic logic [24:0] pick_length();
        int unsigned h;
        int unsigned roll;
        h    = (mask_height_q == 0) ? 1 : 32'(mask_height_q);
        roll = $urandom_range(99);
        if (roll < 8) return 25'd0;
        if (roll < 13) return 25'($urandom_range(0, 1 << 24));
        return 25'($urandom_range(0, 3 * h + 4));
    endfunction

    task automatic send_random_mask();
        int unsigned nruns;
        nruns = $urandom_range(1, 9);
        for (int i = 1; i <= nruns; i++) send_run(pick_length(), i == nruns);
    endtask

    // ---------------------------------------------------------------- tests
    task automatic test_directed();
        send_idle = 0;
        recv_idle = 0;
        // reset height of one row: single foreground run
        send_run(25'd0, 0);
        send_run(25'd5, 1);
        // a background-only mask gives all-zero moments
        send_run(25'd7, 1);
        // partial first, whole middle and partial last column
        write_height(13'd4);
        send_run(25'd3, 0);
        send_run(25'd10, 0);
        send_run(25'd2, 0);
        send_run(25'd7, 1);
        // empty runs still flip the phase
        send_run(25'd0, 0);
        send_run(25'd0, 0);
        send_run(25'd0, 0);
        send_run(25'd4, 1);
        // zero height acts as one row; column index runs past the limit
        write_height(13'd0);
        send_run(25'd0, 0);
        send_run(25'd5000, 1);
        // tallest legal height, a run of 2^24 pixels
        write_height(13'd4096);
        send_run(25'd4095, 0);
        send_run(25'h100_0000, 1);
        // position counter wraps
        send_run(25'd33554422, 0);
        send_run(25'd20, 1);
        // height beyond the legal range, all register bits set
        write_height(13'h1FFF);
        send_run(25'd100, 0);
        send_run(25'h100_0000, 0);
        send_run(25'h0FF_FFFF, 1);
    endtask

    task automatic test_random(input logic [12:0] height, input int unsigned n_runs,
                               input int unsigned s_idle, input int unsigned r_idle);
        int unsigned start;
        write_height(height);
        send_idle = s_idle;
        recv_idle = r_idle;
        start = runs_sent;
        while (runs_sent - start < n_runs) send_random_mask();
    endtask

    // receiver stalls while short masks keep coming, so the input backs up
    task automatic test_backpressure();
        write_height(13'd8);
        send_idle = 0;
        recv_idle = 0;
        -> hold_go;
        repeat (6) begin
            send_run(25'($urandom_range(0, 20)), 0);
            send_run(25'($urandom_range(1, 20)), 1);
        end
        drain_results();
    endtask

    // ---------------------------------------------------------------- main
    initial begin
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        send_idle = 0;
        recv_idle = 0;
        error_count   = 0;
        runs_sent     = 0;
        masks_checked = 0;
        mask_height_q = 13'd1;
        clear_mask_state();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random(13'd1, 70, 6, 73);
        test_random(13'($urandom_range(2, 300)), 70, 6, 73);
        test_random(13'd4096, 70, 73, 6);
        test_random(13'($urandom_range(2, 8191)), 70, 73, 6);
        test_random(13'($urandom_range(2, 64)), 70, 0, 0);
        test_random(13'd0, 40, 0, 0);
        test_backpressure();

        drain_results();
        repeat (200) @(posedge aclk);
        while (pending_moments.size() != 0) begin
            void'(pending_moments.pop_front());
            report_mismatch("expected result never arrived");
        end
        $display("summary: %0d runs sent, %0d mask results checked", runs_sent,
                 masks_checked);
        $display("summary: heights 0, 1, 4096, 8191 and random; idle, stall and hold-off");
        if (error_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

    // watchdog
    initial begin
        #30_000_000;
        $display("testbench: errors");
        $finish;
    end

endmodule

`default_nettype wire
